// ----- rtl/dgsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the dense-graph shortest-path core.
// No dependencies; imported by dense_graph_shortest_path_core.
package dgsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VERTEX_LIMIT = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int WADDR_W      = 2 * VIDX_W;
    localparam int DIST_W       = 17;
    localparam int CFG_W        = 5;
    localparam int FIELD_V_W    = 4;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 24;

    localparam logic [DIST_W-1:0] NO_EDGE = DIST_W'(99999);

    localparam logic OP_EDGE_WRITE = 1'b0;
    localparam logic OP_RUN        = 1'b1;

endpackage

// ----- rtl/dense_graph_shortest_path_core.sv -----
`timescale 1ns / 1ps
// Single-source shortest paths over a dense weight matrix held in block RAM.
// Depends on dgsp_pkg for widths and constants.
//
//  channel  | dir | tdata / tuser                                 | tlast
//  s_*      | in  | tuser: operation; tdata: from, to, weight, src | -
//  m_*      | out | tdata: vertex_index, distance                  | last_result
//  cfg_*    | in  | cfg_wr_data: vertex_count                      | -
//
// After reset all 256 weight RAM entries are cleared to NO_EDGE while s_tready stays low.
// In a run, each settle step scans the distance RAM and then streams one weight row
// against it, both paced by the single read port of each RAM. Results are read from
// the distance RAM and registered one at a time; m_tready low holds the run.
module dense_graph_shortest_path_core
    import dgsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // from[3:0], to[7:4], weight[24:8], src[28:25]
    input  logic                 s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // vertex_index[3:0], distance[20:4]
    output logic                 m_tlast
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_INIT, ST_SELECT, ST_RELAX, ST_OUT_RD, ST_OUT_LD
    } state_t;

    logic [DIST_W-1:0] weight_mem [MAX_VERTICES*MAX_VERTICES];
    logic [DIST_W-1:0] dist_mem   [MAX_VERTICES];

    state_t                  state_reg,    state_next;
    logic [CNT_W-1:0]        idx_reg,      idx_next;
    logic                    p_valid_reg,  p_valid_next;
    logic [VIDX_W-1:0]       p_idx_reg,    p_idx_next;
    logic [CNT_W-1:0]        n_reg,        n_next;
    logic [VIDX_W-1:0]       src_reg,      src_next;
    logic [VIDX_W-1:0]       pick_reg,     pick_next;
    logic [DIST_W-1:0]       best_reg,     best_next;
    logic                    found_reg,    found_next;
    logic                    unreach_reg,  unreach_next;
    logic [MAX_VERTICES-1:0] settled_reg,  settled_next;
    logic [WADDR_W-1:0]      clr_reg,      clr_next;
    logic [CFG_W-1:0]        cfg_n_reg;
    logic                    m_valid_reg,  m_valid_next;
    logic [FIELD_V_W-1:0]    m_index_reg,  m_index_next;
    logic [DIST_W-1:0]       m_dist_reg,   m_dist_next;
    logic                    m_last_reg,   m_last_next;

    logic                    w_we, w_re;
    logic [WADDR_W-1:0]      w_waddr, w_raddr;
    logic [DIST_W-1:0]       w_wdata, w_rdata_reg;
    logic                    d_we, d_re;
    logic [VIDX_W-1:0]       d_waddr, d_raddr;
    logic [DIST_W-1:0]       d_wdata, d_rdata_reg;

    logic [FIELD_V_W-1:0]    in_from, in_to, in_src;
    logic [DIST_W-1:0]       in_weight, sat_weight;
    logic [CNT_W-1:0]        cfg_n;
    logic                    issue, scan_done, s_fire;
    logic [DIST_W-1:0]       edge_len;
    logic [DIST_W:0]         sum_wide;
    logic [DIST_W-1:0]       sum_sat;

    assign in_from   = s_tdata[3:0];
    assign in_to     = s_tdata[7:4];
    assign in_weight = s_tdata[24:8];
    assign in_src    = s_tdata[28:25];
    assign sat_weight = (in_weight > NO_EDGE) ? NO_EDGE : in_weight;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - DIST_W - FIELD_V_W){1'b0}}, m_dist_reg, m_index_reg};

    always_comb begin
        if (cfg_n_reg == '0) begin
            cfg_n = CNT_W'(1);
        end else if (32'(cfg_n_reg) > VERTEX_LIMIT) begin
            cfg_n = CNT_W'(VERTEX_LIMIT);
        end else begin
            cfg_n = CNT_W'(cfg_n_reg);
        end
    end

    assign issue     = (idx_reg < n_reg);
    assign scan_done = !issue && !p_valid_reg;
    assign edge_len  = (p_idx_reg == pick_reg) ? '0 : w_rdata_reg;
    assign sum_wide  = {1'b0, best_reg} + {1'b0, edge_len};
    assign sum_sat   = (sum_wide > {1'b0, NO_EDGE}) ? NO_EDGE : sum_wide[DIST_W-1:0];

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        p_valid_next = 1'b0;
        p_idx_next   = idx_reg[VIDX_W-1:0];
        n_next       = n_reg;
        src_next     = src_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        unreach_next = unreach_reg;
        settled_next = settled_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_index_next = m_index_reg;
        m_dist_next  = m_dist_reg;
        m_last_next  = m_last_reg;
        w_we    = 1'b0;
        w_waddr = {VIDX_W'(in_from), VIDX_W'(in_to)};
        w_wdata = sat_weight;
        w_re    = 1'b0;
        w_raddr = {src_reg, idx_reg[VIDX_W-1:0]};
        d_we    = 1'b0;
        d_waddr = p_idx_reg;
        d_wdata = sum_sat;
        d_re    = 1'b0;
        d_raddr = idx_reg[VIDX_W-1:0];

        case (state_reg)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                w_wdata = NO_EDGE;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == OP_EDGE_WRITE) begin
                        w_we = (32'(in_from) < MAX_VERTICES) && (32'(in_to) < MAX_VERTICES);
                    end else begin
                        n_next   = cfg_n;
                        idx_next = '0;
                        src_next = VIDX_W'(in_src);
                        if (32'(in_src) >= 32'(cfg_n)) begin
                            unreach_next = 1'b1;
                            state_next   = ST_OUT_RD;
                        end else begin
                            unreach_next = 1'b0;
                            settled_next = '0;
                            settled_next[VIDX_W'(in_src)] = 1'b1;
                            state_next   = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                w_re         = issue;
                p_valid_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                d_we    = p_valid_reg;
                d_wdata = (p_idx_reg == src_reg) ? '0 : w_rdata_reg;
                if (scan_done) begin
                    idx_next   = '0;
                    best_next  = NO_EDGE;
                    found_next = 1'b0;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                d_re         = issue;
                p_valid_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (p_valid_reg && !settled_reg[p_idx_reg] && (d_rdata_reg < best_reg)) begin
                    best_next  = d_rdata_reg;
                    pick_next  = p_idx_reg;
                    found_next = 1'b1;
                end
                if (scan_done) begin
                    idx_next = '0;
                    if (found_reg) begin
                        settled_next[pick_reg] = 1'b1;
                        state_next = ST_RELAX;
                    end else begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_RELAX: begin
                w_re         = issue;
                w_raddr      = {pick_reg, idx_reg[VIDX_W-1:0]};
                d_re         = issue;
                p_valid_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                d_we = p_valid_reg && !settled_reg[p_idx_reg] && (sum_sat < d_rdata_reg);
                if (scan_done) begin
                    idx_next   = '0;
                    best_next  = NO_EDGE;
                    found_next = 1'b0;
                    state_next = ST_SELECT;
                end
            end
            ST_OUT_RD: begin
                d_re       = 1'b1;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_index_next = FIELD_V_W'(idx_reg);
                    m_dist_next  = unreach_reg ? NO_EDGE : d_rdata_reg;
                    m_last_next  = (idx_reg + 1'b1 == n_reg);
                    idx_next     = idx_reg + 1'b1;
                    state_next   = (idx_reg + 1'b1 == n_reg) ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cfg_n_reg   <= CFG_W'(16);
            m_valid_reg <= 1'b0;
            settled_reg <= '0;
            p_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            unreach_reg <= 1'b0;
            idx_reg     <= '0;
            n_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            if (cfg_wr_en) begin
                cfg_n_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
            settled_reg <= settled_next;
            p_valid_reg <= p_valid_next;
            found_reg   <= found_next;
            unreach_reg <= unreach_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
        end
        p_idx_reg   <= p_idx_next;
        src_reg     <= src_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        m_index_reg <= m_index_next;
        m_dist_reg  <= m_dist_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            weight_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            w_rdata_reg <= weight_mem[w_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (d_we) begin
            dist_mem[d_waddr] <= d_wdata;
        end
        if (d_re) begin
            d_rdata_reg <= dist_mem[d_raddr];
        end
    end

endmodule

// ----- bench/dense_graph_shortest_path_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for dense_graph_shortest_path_core: edge-write and run requests are
// checked against an in-bench shortest-path predictor, with bursty input and
// random output stalls. Depends on rtl/dgsp_pkg.sv and the core RTL.
module dense_graph_shortest_path_core_tb;
    import dgsp_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int IDLE_SETTLE  = 8;
    localparam int RANDOM_ITEMS = 150;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic [DIST_W-1:0] dval;
        logic              last;
    } dist_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic [DIST_W-1:0] weight_store [MAX_VERTICES][MAX_VERTICES];
    logic [CFG_W-1:0]  vcount_q;
    dist_result_t      expected_dist_q [$];
    dist_result_t      exp_r;

    int cycle_count;
    int mismatch_count;
    int unexpected_count;
    int results_seen;
    int writes_sent;
    int runs_sent;
    int burst_left;
    int rx_span = 0;
    int rx_mode = 0;

    dense_graph_shortest_path_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d distances pending",
                     cycle_count, expected_dist_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: spans of always-ready, coin-flip and mostly-stalled behavior
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_span <= $urandom_range(20, 200);
            rx_mode <= $urandom_range(0, 2);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_dist_q.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected distance: vertex %0d dist %0d last %0b",
                             m_tdata[3:0], m_tdata[20:4], m_tlast);
            end else begin
                exp_r = expected_dist_q.pop_front();
                if (m_tdata[3:0] !== exp_r.vidx || m_tdata[20:4] !== exp_r.dval ||
                    m_tlast !== exp_r.last) begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("mismatch: exp vertex %0d dist %0d last %0b, got %0d %0d %0b",
                                 exp_r.vidx, exp_r.dval, exp_r.last,
                                 m_tdata[3:0], m_tdata[20:4], m_tlast);
                end
            end
        end
    end

    function automatic int active_vertices();
        if (vcount_q == 0)
            return 1;
        if (vcount_q > VERTEX_LIMIT)
            return VERTEX_LIMIT;
        return vcount_q;
    endfunction

    function automatic int edge_weight_at(int a, int b);
        if (a == b)
            return 0;
        return weight_store[a][b];
    endfunction

    task automatic predict_distances(input logic [VIDX_W-1:0] src);
        int n, k, i, w, pick, best, sum;
        bit found;
        int path_len [MAX_VERTICES];
        bit settled [MAX_VERTICES];
        dist_result_t r;
        n = active_vertices();
        for (i = 0; i < n; i++) begin
            settled[i] = 1'b0;
            path_len[i] = (src >= n) ? int'(NO_EDGE) : edge_weight_at(src, i);
        end
        if (src < n) begin
            settled[src] = 1'b1;
            path_len[src] = 0;
            for (k = 0; k < n; k++) begin
                best = NO_EDGE;
                pick = 0;
                found = 1'b0;
                for (i = 0; i < n; i++) begin
                    if (!settled[i] && path_len[i] < best) begin
                        best = path_len[i];
                        pick = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    break;
                settled[pick] = 1'b1;
                for (w = 0; w < n; w++) begin
                    if (!settled[w]) begin
                        sum = path_len[pick] + edge_weight_at(pick, w);
                        if (sum > NO_EDGE)
                            sum = NO_EDGE;
                        if (sum < path_len[w])
                            path_len[w] = sum;
                    end
                end
            end
        end
        for (i = 0; i < n; i++) begin
            r.vidx = VIDX_W'(i);
            r.dval = DIST_W'(path_len[i]);
            r.last = (i == n - 1);
            expected_dist_q.push_back(r);
        end
    endtask

    task automatic send_request(input logic op, input logic [3:0] from_v,
                                input logic [3:0] to_v, input logic [DIST_W-1:0] weight,
                                input logic [3:0] src);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, src, weight, to_v, from_v};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_EDGE_WRITE) begin
            weight_store[from_v][to_v] = (weight > NO_EDGE) ? NO_EDGE : weight;
            writes_sent++;
        end else begin
            predict_distances(src);
            runs_sent++;
        end
    endtask

    task automatic write_edge(input int a, input int b, input int w);
        send_request(OP_EDGE_WRITE, 4'(a), 4'(b), DIST_W'(w), 4'($urandom_range(0, 15)));
    endtask

    task automatic run_from(input int src);
        send_request(OP_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     DIST_W'($urandom_range(0, 131071)), 4'(src));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_dist_q.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input int v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(posedge aclk);
        vcount_q = CFG_W'(v);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int rand_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 50);
            4, 5:       return $urandom_range(1000, 60000);
            6:          return $urandom_range(0, 99999);
            7:          return NO_EDGE;
            default:    return $urandom_range(99990, 131071);
        endcase
    endfunction

    function automatic int pick_vertex(int n);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(0, n - 1);
    endfunction

    // zero edge, relax improvement, near-max and saturating sums, diagonal,
    // heavy weight, explicit no-edge, equal-distance tie
    task automatic test_directed_edges();
        write_edge(0, 1, 0);
        write_edge(1, 2, 5);
        write_edge(0, 2, 10);
        write_edge(2, 3, 99998);
        write_edge(0, 4, 99998);
        write_edge(4, 5, 1);
        write_edge(0, 0, 7);
        write_edge(15, 14, 131071);
        write_edge(0, 15, NO_EDGE);
        write_edge(0, 6, 3);
        write_edge(0, 7, 3);
        write_edge(7, 15, 2);
        run_from(0);
        run_from(15);
        run_from(7);
    endtask

    task automatic test_vertex_count_extremes();
        write_vertex_count(0);
        run_from(0);
        run_from(1);
        write_vertex_count(31);
        run_from(0);
        write_vertex_count(5);
        run_from(7);
        run_from(2);
        write_vertex_count(1);
        run_from(0);
        write_vertex_count(16);
        run_from(15);
    endtask

    task automatic test_random_graphs();
        int sent, n, k, j;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: write_vertex_count(16);
                3:       write_vertex_count($urandom_range(17, 31));
                4:       write_vertex_count(0);
                default: write_vertex_count($urandom_range(2, 8));
            endcase
            n = active_vertices();
            repeat ($urandom_range(1, 3)) begin
                k = $urandom_range(3, 12);
                for (j = 0; j < k; j++)
                    write_edge(pick_vertex(n), pick_vertex(n), rand_weight());
                run_from(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, n - 1));
                if ($urandom_range(0, 3) == 0) begin
                    run_from($urandom_range(0, 15));
                    sent++;
                end
                sent += k + 1;
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_EDGE_WRITE;
        s_tdata     <= '0;
        burst_left  = 0;
        vcount_q    = 16;
        for (int a = 0; a < MAX_VERTICES; a++)
            for (int b = 0; b < MAX_VERTICES; b++)
                weight_store[a][b] = NO_EDGE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_vertex_count_extremes();
        test_random_graphs();

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("covered %0d edge writes and %0d runs, %0d distances returned",
                 writes_sent, runs_sent, results_seen);
        $display("vertex counts 0, 1, 5, 16 and above the limit, bursty input, stalled output");
        if (mismatch_count == 0 && unexpected_count == 0 && expected_dist_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
